>>> rtl/dlfm_pkg.sv
// ----------------------------------------------------------------------------
// dlfm_pkg
// Shared types and fixed-point constants of the dense layer MAC core.
// ----------------------------------------------------------------------------
package dlfm_pkg;

   // fixed-point format of data items and accumulators
   localparam int DataW    = 16;
   localparam int FracBits = 12;
   localparam int AccW     = 40;
   localparam int ProdW    = 2 * DataW;

   // field widths of the request and result items
   localparam int KindW    = 2;
   localparam int NeuronW  = 4;
   localparam int ColumnW  = 6;
   localparam int IndexW   = 4;
   localparam int InCountW = 7;
   localparam int OutCountW = 5;

   // widest weight address the chain carries (largest input count)
   localparam int LinkAddrW = 10;

   // register reset values
   localparam logic [InCountW-1:0]  InCountReset  = 7'd64;
   localparam logic [OutCountW-1:0] OutCountReset = 5'd16;

   // request item kinds as they arrive on tuser
   typedef enum logic [KindW-1:0] {
      KIND_WEIGHT = 2'd0,
      KIND_BIAS   = 2'd1,
      KIND_ELEM   = 2'd2
   } req_kind_type;

   // what travels down the chain of cells
   typedef enum logic [1:0] {
      LK_NONE,
      LK_WEIGHT,
      LK_BIAS,
      LK_ELEM
   } link_kind_type;

   typedef struct packed {
      link_kind_type          kind;
      logic                   tail;
      logic [NeuronW-1:0]     neuron;
      logic [LinkAddrW-1:0]   addr;
      logic [DataW-1:0]       value;
   } link_type;

   // configuration register indexes
   typedef enum logic {
      CSR_IN_COUNT  = 1'b0,
      CSR_OUT_COUNT = 1'b1
   } csr_index_type;

   // top level sequencer states
   typedef enum logic [1:0] {
      ST_RUN,
      ST_WAIT,
      ST_DRAIN
   } state_type;

endpackage

>>> rtl/dlfm_ram.sv
// ----------------------------------------------------------------------------
// dlfm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dlfm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dlfm_cell.sv
// ----------------------------------------------------------------------------
// dlfm_cell
// One output neuron: weight column, bias, multiply-accumulate and result
// register. Passes the link item and the result chain to its neighbors.
// ----------------------------------------------------------------------------
module dlfm_cell
   import dlfm_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int DEPTH      = 64,
   localparam int AddrW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  link_type         link_in,
   output link_type         link_out,
   input  logic             shift_en,
   input  logic [DataW-1:0] res_in,
   output logic [DataW-1:0] res_out
);

   localparam int SumW      = AccW + 2;
   localparam int ShW       = SumW - FracBits;
   localparam int RoundHalf = (FracBits > 0) ? (1 << (FracBits - 1)) : 0;
   localparam logic signed [ShW-1:0] SatHi = ShW'((1 << (DataW - 1)) - 1);
   localparam logic signed [ShW-1:0] SatLo = ~SatHi;

   // bias add, round half up, scale back and saturate
   function automatic logic [DataW-1:0] finish_value(
      input logic signed [AccW-1:0]  acc,
      input logic signed [DataW-1:0] bias
   );
      logic signed [SumW-1:0] sum;
      logic signed [ShW-1:0]  sh;
      sum = SumW'(acc) + (SumW'(bias) <<< FracBits) + SumW'(RoundHalf);
      sh  = ShW'(sum >>> FracBits);
      if (sh > SatHi) begin
         finish_value = DataW'(SatHi);
      end else if (sh < SatLo) begin
         finish_value = DataW'(SatLo);
      end else begin
         finish_value = DataW'(sh);
      end
   endfunction

   link_type                link_ff;
   logic                    mine;
   logic                    wr_en;
   logic [DataW-1:0]        weight;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;
   logic                    prod_valid_ff;
   logic                    prod_tail_ff;
   logic signed [AccW-1:0]  acc_ff;
   logic signed [AccW-1:0]  acc_in;
   logic                    fin_ff;
   logic [DataW-1:0]        bias_ff;
   logic [DataW-1:0]        res_ff;
   logic [DataW-1:0]        res_in_sel;

   // load addressed to this neuron
   assign mine  = ({4'b0, link_in.neuron} == 8'(CELL_INDEX));
   assign wr_en = (link_in.kind == LK_WEIGHT) && mine;

   dlfm_ram #(
      .WIDTH (DataW),
      .DEPTH (DEPTH)
   ) u_weights (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (link_in.addr[AddrW-1:0]),
      .wr_data (link_in.value),
      .rd_addr (link_in.addr[AddrW-1:0]),
      .rd_data (weight)
   );

   // link stage, handed to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.kind <= LK_NONE;
      end else begin
         link_ff.kind <= link_in.kind;
      end
      link_ff.tail   <= link_in.tail;
      link_ff.neuron <= link_in.neuron;
      link_ff.addr   <= link_in.addr;
      link_ff.value  <= link_in.value;
   end

   assign link_out = link_ff;

   // bias register
   always_ff @(posedge clock) begin
      if ((link_in.kind == LK_BIAS) && mine) begin
         bias_ff <= link_in.value;
      end
   end

   // product stage
   assign prod_in = $signed(weight) * $signed(link_ff.value);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         prod_tail_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= (link_ff.kind == LK_ELEM);
         prod_tail_ff  <= link_ff.tail;
      end
      prod_ff <= prod_in;
   end

   // accumulate, cleared once the result is captured
   always_comb begin
      acc_in = acc_ff;
      if (fin_ff) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + AccW'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         fin_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         fin_ff <= prod_valid_ff && prod_tail_ff;
      end
   end

   // result register: capture at vector end, else shift toward cell 0
   always_comb begin
      res_in_sel = res_ff;
      if (fin_ff) begin
         res_in_sel = finish_value(acc_ff, bias_ff);
      end else if (shift_en) begin
         res_in_sel = res_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in_sel;
   end

   assign res_out = res_ff;

endmodule

>>> rtl/dense_layer_forward_mac_core.sv
// ----------------------------------------------------------------------------
// dense_layer_forward_mac_core
// Fully connected layer forward pass in Q4.12 over a chain of MAC cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: weight loads, bias loads and input elements, kind on tuser.
//   Loads and elements are taken one per cycle while req_tready is high;
//   each item walks down a chain of MAX_OUTPUTS cells, one cell per cycle,
//   so loads and elements keep their order in every cell.
//   The element that ends a vector (position input_count-1) holds req_tready
//   low: the block waits for that element to reach and settle in the last
//   cell, then delivers output_count results, one per cycle while rsp is
//   not stalled, from the rsp channel, the last one with rsp_tlast. req_tready
//   rises again when the last result is in the output register.
//   A count of zero acts as one, a count above its maximum as the maximum.
//   A stall on rsp holds the output register and pauses the drain.
//   csr port: input_count at 0x0, output_count at 0x4.
//   Reset clears accumulators, position and handshake state, and sets
//   input_count to 64 and output_count to 16. Weights and biases must be
//   loaded before use.
// ----------------------------------------------------------------------------
module dense_layer_forward_mac_core
   import dlfm_pkg::*;
#(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OUTPUTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // neuron[3:0], column[9:4], value[25:10]
   input  logic [1:0]  req_tuser,   // kind[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_index[3:0], out_value[19:4]
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CmpW  = ($clog2(MAX_INPUTS + 1) > 8) ? $clog2(MAX_INPUTS + 1) : 8;
   localparam int IdxW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int WaitW = $clog2(MAX_OUTPUTS + 2);

   // request fields
   logic [NeuronW-1:0] neuron;
   logic [ColumnW-1:0] column;
   logic [DataW-1:0]   value;
   req_kind_type       kind;

   assign neuron = req_tdata[3:0];
   assign column = req_tdata[9:4];
   assign value  = req_tdata[25:10];
   assign kind   = req_kind_type'(req_tuser);

   // configuration registers
   logic [InCountW-1:0]  in_count_ff;
   logic [OutCountW-1:0] out_count_ff;
   logic                 csr_write;
   csr_index_type        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= InCountReset;
         out_count_ff <= OutCountReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IN_COUNT:  in_count_ff  <= csr_pwdata[InCountW-1:0];
            CSR_OUT_COUNT: out_count_ff <= csr_pwdata[OutCountW-1:0];
            default:       in_count_ff  <= in_count_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_IN_COUNT:  csr_prdata = 32'(in_count_ff);
         CSR_OUT_COUNT: csr_prdata = 32'(out_count_ff);
         default:       csr_prdata = '0;
      endcase
   end

   // clamped counts
   logic [CmpW-1:0] n_in;
   logic [7:0]      n_out;

   always_comb begin
      if (in_count_ff == '0) begin
         n_in = CmpW'(1);
      end else if (CmpW'(in_count_ff) > CmpW'(MAX_INPUTS)) begin
         n_in = CmpW'(MAX_INPUTS);
      end else begin
         n_in = CmpW'(in_count_ff);
      end
      if (out_count_ff == '0) begin
         n_out = 8'd1;
      end else if (8'(out_count_ff) > 8'(MAX_OUTPUTS)) begin
         n_out = 8'(MAX_OUTPUTS);
      end else begin
         n_out = 8'(out_count_ff);
      end
   end

   // sequencer state
   state_type             state_ff, state_in;
   logic [WaitW-1:0]      wait_ff, wait_in;
   logic [IdxW-1:0]       idx_ff, idx_in;
   logic [InCountW-1:0]   pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IndexW-1:0]     rsp_index_ff, rsp_index_in;
   logic [DataW-1:0]      rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  accept;
   logic                  tail;
   logic                  shift_en;
   logic                  drain_last;
   link_type              head;
   logic [DataW-1:0]      res_chain [MAX_OUTPUTS];
   link_type              links [MAX_OUTPUTS];

   assign accept     = req_tvalid && req_tready;
   assign tail       = (CmpW'(pos_ff) + CmpW'(1)) >= n_in;
   assign drain_last = (8'(idx_ff) + 8'd1) == n_out;

   // item entering the chain
   always_comb begin
      head.kind   = LK_NONE;
      head.tail   = 1'b0;
      head.neuron = neuron;
      head.addr   = LinkAddrW'(column);
      head.value  = value;
      if (accept) begin
         unique case (kind)
            KIND_WEIGHT: begin
               if (({4'b0, neuron} < 8'(MAX_OUTPUTS))
                   && (CmpW'(column) < CmpW'(MAX_INPUTS))) begin
                  head.kind = LK_WEIGHT;
               end
            end
            KIND_BIAS: begin
               if ({4'b0, neuron} < 8'(MAX_OUTPUTS)) begin
                  head.kind = LK_BIAS;
               end
            end
            KIND_ELEM: begin
               head.kind = LK_ELEM;
               head.tail = tail;
               head.addr = LinkAddrW'(pos_ff);
            end
            default: head.kind = LK_NONE;
         endcase
      end
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      shift_en     = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_tready = 1'b1;
            if (accept && (kind == KIND_ELEM)) begin
               if (tail) begin
                  pos_in   = '0;
                  wait_in  = '0;
                  state_in = ST_WAIT;
               end else begin
                  pos_in = pos_ff + InCountW'(1);
               end
            end
         end
         ST_WAIT: begin
            wait_in = wait_ff + WaitW'(1);
            if (wait_ff == WaitW'(MAX_OUTPUTS + 1)) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               shift_en     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_index_in = IndexW'(idx_ff);
               rsp_value_in = res_chain[0];
               rsp_last_in  = drain_last;
               idx_in       = idx_ff + IdxW'(1);
               if (drain_last) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         wait_ff      <= '0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         idx_ff       <= idx_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_value_ff, rsp_index_ff};
   assign rsp_tlast  = rsp_last_ff;

   // chain of neuron cells
   assign links[0] = head;

   for (genvar j = 0; j < MAX_OUTPUTS; j++) begin : g_cell
      logic [DataW-1:0] res_next;
      link_type         link_next;

      if (j == MAX_OUTPUTS - 1) begin : g_end
         assign res_next = '0;
      end else begin : g_mid
         assign res_next     = res_chain[j + 1];
         assign links[j + 1] = link_next;
      end

      dlfm_cell #(
         .CELL_INDEX (j),
         .DEPTH      (MAX_INPUTS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (links[j]),
         .link_out (link_next),
         .shift_en (shift_en),
         .res_in   (res_next),
         .res_out  (res_chain[j])
      );
   end

endmodule

>>> rtl/dlfm_checker.sv
// ----------------------------------------------------------------------------
// dlfm_checker
// Port-level checks of the dense layer MAC core, bound to the top level.
// ----------------------------------------------------------------------------
module dlfm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // no new item is taken while a vector drains
   a_busy_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during drain");

   // results of one vector follow without a gap
   a_drain_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a result burst");

   // neuron index counts up inside a burst
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd1)
      else $error("result index out of sequence");

endmodule

bind dense_layer_forward_mac_core dlfm_checker u_dlfm_checker (.*);

>>> dv/dense_layer_forward_mac_core_test.sv
// ----------------------------------------------------------------------------
// dense_layer_forward_mac_core_test
// Self-checking bench for the dense layer MAC core: fills the weight and bias
// tables, streams input vectors under several layer sizes and idle patterns,
// predicts every saturated neuron output and compares it field by field.
// ----------------------------------------------------------------------------
module dense_layer_forward_mac_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import dlfm_pkg::*;

   localparam int MaxInputs   = 64;
   localparam int MaxOutputs  = 16;
   // input positions the stimulus reaches; input counts stay at or below it
   localparam int UsedInputs  = 4;
   localparam int ChainSettle = MaxOutputs + 8;
   localparam int CycleLimit  = 200000;
   localparam longint SatHigh = (longint'(1) <<< (DataW - 1)) - 1;
   localparam longint SatLow  = -SatHigh - 1;
   // kind code outside the defined set, ignored by the core
   localparam logic [KindW-1:0] KindUnused = 2'd3;

   typedef struct {
      logic [KindW-1:0]        kind;
      logic [NeuronW-1:0]      neuron;
      logic [ColumnW-1:0]      column;
      logic signed [DataW-1:0] value;
   } layer_item_type;

   typedef struct {
      logic [IndexW-1:0]       index;
      logic signed [DataW-1:0] value;
      logic                    last;
   } neuron_out_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // neuron[3:0], column[9:4], value[25:10]
   logic [1:0]  req_tuser   = '0;   // kind[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // out_index[3:0], out_value[19:4]
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // items waiting for the driver and neuron outputs waiting for the core
   layer_item_type req_items_q[$];
   neuron_out_type neuron_results_q[$];

   // shadow copy of the layer state
   logic signed [DataW-1:0] weight_mem [MaxOutputs][MaxInputs];
   logic signed [DataW-1:0] bias_mem [MaxOutputs];
   logic signed [AccW-1:0]  acc_mem [MaxOutputs];
   int                      elem_pos = 0;
   logic [InCountW-1:0]     in_count_reg  = InCountReset;
   logic [OutCountW-1:0]    out_count_reg = OutCountReset;

   int error_count    = 0;
   int cycle_count    = 0;
   int send_gap_pct   = 0;
   int resp_stall_pct = 0;

   dense_layer_forward_mac_core #(
      .MAX_INPUTS (MaxInputs),
      .MAX_OUTPUTS(MaxOutputs)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bias added in product format, round half up, saturate to data width
   function automatic logic signed [DataW-1:0] neuron_output(
      logic signed [AccW-1:0] acc, logic signed [DataW-1:0] bias);
      longint sum;
      sum = longint'(acc) + (longint'(bias) <<< FracBits)
            + (longint'(1) <<< (FracBits - 1));
      sum = sum >>> FracBits;
      if (sum > SatHigh) return DataW'(SatHigh);
      if (sum < SatLow) return DataW'(SatLow);
      return DataW'(sum);
   endfunction

   // update the shadow layer with one accepted item, queue any outputs
   function automatic void apply_layer_item(layer_item_type item);
      int             n_in;
      int             n_out;
      longint         prod;
      neuron_out_type res;
      case (item.kind)
         KIND_WEIGHT: weight_mem[item.neuron][item.column] = item.value;
         KIND_BIAS:   bias_mem[item.neuron] = item.value;
         KIND_ELEM: begin
            n_in  = (in_count_reg == 0) ? 1 :
                    (in_count_reg > MaxInputs) ? MaxInputs : int'(in_count_reg);
            n_out = (out_count_reg == 0) ? 1 :
                    (out_count_reg > MaxOutputs) ? MaxOutputs : int'(out_count_reg);
            // every accumulator takes the product, used or not
            if (elem_pos < MaxInputs) begin
               for (int j = 0; j < MaxOutputs; j++) begin
                  prod = longint'(item.value) * longint'(weight_mem[j][elem_pos]);
                  acc_mem[j] = AccW'(longint'(acc_mem[j]) + prod);
               end
            end
            // a position at or past the end closes the vector
            if (elem_pos + 1 < n_in) begin
               elem_pos++;
            end else begin
               for (int j = 0; j < n_out; j++) begin
                  res.index = IndexW'(j);
                  res.value = neuron_output(acc_mem[j], bias_mem[j]);
                  res.last  = (j == n_out - 1);
                  neuron_results_q.push_back(res);
               end
               foreach (acc_mem[j]) acc_mem[j] = '0;
               elem_pos = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // mix of extremes, small fractions and full-range values
   function automatic logic signed [DataW-1:0] rand_q412();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3, 4: return DataW'(int'($urandom_range(4095)) - 2048);
         default: return DataW'($urandom);
      endcase
   endfunction

   function automatic void queue_item(logic [KindW-1:0] kind, int neuron, int column,
                                      logic signed [DataW-1:0] value);
      layer_item_type item;
      item.kind   = kind;
      item.neuron = NeuronW'(neuron);
      item.column = ColumnW'(column);
      item.value  = value;
      req_items_q.push_back(item);
   endfunction

   // apb write: setup cycle then access cycle
   task automatic write_csr(csr_index_type idx, int unsigned val);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         CSR_IN_COUNT:  in_count_reg  = val[InCountW-1:0];
         CSR_OUT_COUNT: out_count_reg = val[OutCountW-1:0];
         default: ;
      endcase
   endtask

   task automatic set_layer_size(int unsigned n_in, int unsigned n_out);
      write_csr(CSR_IN_COUNT, n_in);
      write_csr(CSR_OUT_COUNT, n_out);
   endtask

   // hold until the driver is empty and every output is back, then let the chain drain
   task automatic wait_for_results();
      @(negedge clock);
      while (req_items_q.size() != 0 || req_tvalid || neuron_results_q.size() != 0)
         @(negedge clock);
      repeat (ChainSettle) @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      layer_item_type bus_item;
      layer_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            bus_item.kind   = req_tuser;
            bus_item.neuron = req_tdata[3:0];
            bus_item.column = req_tdata[9:4];
            bus_item.value  = req_tdata[25:10];
            apply_layer_item(bus_item);
         end
         if (!req_tvalid || req_tready) begin
            if (req_items_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_item = req_items_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_item.kind;
               req_tdata  <= {6'b0, next_item.value, next_item.column, next_item.neuron};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin : check_rsp
      neuron_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (neuron_results_q.size() == 0) begin
               $display("%0t: unexpected result index %0d value %0d last %0b", $time,
                        rsp_tdata[3:0], $signed(rsp_tdata[19:4]), rsp_tlast);
               error_count++;
            end else begin
               want = neuron_results_q.pop_front();
               if (rsp_tdata[3:0] !== want.index) begin
                  $display("%0t: out_index expected %0d actual %0d", $time,
                           want.index, rsp_tdata[3:0]);
                  error_count++;
               end
               if ($signed(rsp_tdata[19:4]) !== want.value) begin
                  $display("%0t: out_value expected %0d actual %0d (index %0d)", $time,
                           want.value, $signed(rsp_tdata[19:4]), want.index);
                  error_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last expected %0b actual %0b (index %0d)", $time,
                           want.last, rsp_tlast, want.index);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= resp_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("dense_layer_forward_mac_core_test failed");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      int          size_in [6];
      int          size_out [6];
      int          item_cnt [6];
      int          elem_pct;
      int          pick;
      logic [KindW-1:0] kind;
      size_in  = '{3, 4, 0, 1, 0, 2};
      size_out = '{7, 16, 0, 1, 16, 31};
      item_cnt = '{8, 10, 6, 4, 4, 4};
      size_in[2]  = $urandom_range(1, UsedInputs);
      size_out[2] = $urandom_range(1, 16);
      size_in[4]  = $urandom_range(2, UsedInputs);
      foreach (acc_mem[j]) acc_mem[j] = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct   = 7;
      resp_stall_pct = 48;

      // weights of every position in use and every bias, before any element reads them
      for (int j = 0; j < MaxOutputs; j++)
         for (int k = 0; k < UsedInputs; k++)
            queue_item(KIND_WEIGHT, j, k, rand_q412());
      for (int j = 0; j < MaxOutputs; j++)
         queue_item(KIND_BIAS, j, $urandom_range(63), rand_q412());
      // extreme weights and biases, half-lsb weight on neuron 2 for rounding
      queue_item(KIND_WEIGHT, 0, 0, 16'sh7FFF);
      queue_item(KIND_WEIGHT, 1, 0, 16'sh8000);
      queue_item(KIND_WEIGHT, 2, 0, 16'sh0800);
      queue_item(KIND_BIAS, 0, 0, 16'sh7FFF);
      queue_item(KIND_BIAS, 1, 0, 16'sh8000);
      queue_item(KIND_BIAS, 2, 0, 16'sh0000);
      wait_for_results();

      // single-element vectors: extreme inputs, rounding ties, unused kind
      set_layer_size(1, 16);
      queue_item(KIND_ELEM, 0, 0, 16'sh7FFF);
      queue_item(KIND_ELEM, 15, 63, 16'sh8000);
      queue_item(KIND_ELEM, 0, 0, 16'sh0000);
      queue_item(KindUnused, 15, 63, 16'sh7FFF);
      queue_item(KIND_ELEM, 0, 0, 16'sh0001);
      queue_item(KIND_ELEM, 0, 0, 16'shFFFF);
      queue_item(KIND_ELEM, 0, 0, 16'sh1000);
      wait_for_results();
      // output count zero acts as one
      set_layer_size(1, 0);
      queue_item(KIND_ELEM, 0, 0, rand_q412());
      wait_for_results();
      // input count zero acts as one, output count above range acts as max
      set_layer_size(0, 31);
      queue_item(KIND_ELEM, 0, 0, rand_q412());
      wait_for_results();
      // count lowered under the current position ends the vector on the next element
      set_layer_size(4, 5);
      for (int i = 0; i < 3; i++) queue_item(KIND_ELEM, 0, 0, rand_q412());
      wait_for_results();
      set_layer_size(2, 5);
      queue_item(KIND_ELEM, 0, 0, rand_q412());

      // random vectors with loads and noise mixed in
      for (int p = 0; p < 6; p++) begin
         wait_for_results();
         if (p == 2) begin
            send_gap_pct   = 48;
            resp_stall_pct = 7;
         end
         if (p == 4) begin
            send_gap_pct   = 0;
            resp_stall_pct = 0;
         end
         set_layer_size(size_in[p], size_out[p]);
         elem_pct = (p == 1) ? 92 : 80;
         for (int i = 0; i < item_cnt[p]; i++) begin
            if (p == 2 && i == item_cnt[p] / 2) wait_for_results();
            pick = $urandom_range(99);
            if (pick < elem_pct) kind = KIND_ELEM;
            else if (pick < elem_pct + 5) kind = KIND_WEIGHT;
            else if (pick < elem_pct + 8) kind = KIND_BIAS;
            else kind = KindUnused;
            queue_item(kind, $urandom_range(15), $urandom_range(63), rand_q412());
         end
      end

      wait_for_results();
      if (error_count == 0) begin
         $display("dense_layer_forward_mac_core_test passed");
      end else begin
         $display("dense_layer_forward_mac_core_test failed");
      end
      $finish;
   end

endmodule
